/* rtl/core/tmte_pkg.sv */
// Shared definitions of the tape machine token executor: field widths,
// action codes, default depths and the modulo reduction step.
// No dependencies; used by the core and its checker.
package tmte_pkg;

	localparam int ACT_W  = 4;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 16;

	// The reduction constant is a depth of at most 2**IDX_W shifted left by up to 8.
	localparam int MOD_W = IDX_W + 9;

	localparam int TAPE_DEPTH_DEF = 65536;
	localparam int PROG_DEPTH_DEF = 65536;

	typedef enum logic [ACT_W-1:0] {
		ACT_RIGHT = 4'd0,
		ACT_LEFT  = 4'd1,
		ACT_ADD   = 4'd2,
		ACT_SUB   = 4'd3,
		ACT_OUT   = 4'd4,
		ACT_IN    = 4'd5,
		ACT_JZ    = 4'd6,
		ACT_JNZ   = 4'd7,
		ACT_EXIT  = 4'd8,
		ACT_NOP   = 4'd9
	} action_t;

	// One restoring step of x mod d: subtract the shifted divisor when it fits.
	function automatic logic [IDX_W:0] mod_step(input logic [IDX_W:0] x,
	                                             input logic [MOD_W-1:0] m);
		logic [IDX_W:0] r;
		r = (MOD_W'(x) >= m) ? (x - m[IDX_W:0]) : x;
		return r;
	endfunction

endpackage

/* rtl/core/tmte_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tmte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/tape_machine_token_executor_core.sv */
// A word accepted in S_IDLE moves to S_EXEC, where its result word is registered once the
// output register is free. A new input word is taken only after the last one has finished,
// set by the read-modify-write of one tape cell in the tape RAM (read on accept, modify and write back on finish).
// Reset (arst_n low, asynchronous) clears pointer, program index, stop flag and safe_mode,
// then a clearing pass writes zero to every tape cell, one per cycle;
// no input word is accepted during that pass, configuration writes are taken as always.
module tape_machine_token_executor_core #(
	parameter int TAPE_DEPTH    = tmte_pkg::TAPE_DEPTH_DEF,
	parameter int PROGRAM_DEPTH = tmte_pkg::PROG_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration: safe_mode register.
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	// Input words (one program token each).
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tmte_pkg::ACT_W-1:0]  action,
	input  logic [tmte_pkg::BYTE_W-1:0] amount,
	input  logic [tmte_pkg::IDX_W-1:0]  match_index,
	input  logic [tmte_pkg::BYTE_W-1:0] input_byte,
	// Result words.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tmte_pkg::BYTE_W-1:0] out_byte,
	output logic [tmte_pkg::BYTE_W-1:0] out_count,
	output logic [tmte_pkg::IDX_W-1:0]  next_index,
	output logic                        halted,
	output logic                        fault
);

	// Tape address width and program index width.
	localparam int AW = $clog2(TAPE_DEPTH);
	localparam int PW = $clog2(PROGRAM_DEPTH);
	localparam int BW = tmte_pkg::BYTE_W;
	localparam int XW = tmte_pkg::IDX_W + 1;

	// A jump target is match_index + 1, at most 2**IDX_W. Reducing it modulo PROGRAM_DEPTH
	// needs QB restoring steps; the upper steps run in the accept cycle, the rest in the
	// execute cycle.
	localparam int IDX_SPAN = 1 << tmte_pkg::IDX_W;
	localparam int QB       = $clog2(IDX_SPAN / PROGRAM_DEPTH + 1);
	localparam int SPLIT    = QB / 2;

	localparam logic [AW:0]   TAPE_LIM = (AW + 1)'(TAPE_DEPTH);
	localparam logic [PW-1:0] PROG_MAX = PW'(PROGRAM_DEPTH - 1);
	localparam logic [AW-1:0] TAPE_MAX = AW'(TAPE_DEPTH - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	// Architectural state outside the tape.
	logic [AW-1:0] dp_q;
	logic [PW-1:0] pidx_q;
	logic          stopped_q;
	logic          safe_mode_q;
	logic [AW-1:0] clr_q;

	// Token captured at accept time.
	logic [tmte_pkg::ACT_W-1:0] action_s1;
	logic [BW-1:0]              amount_s1;
	logic [BW-1:0]              ibyte_s1;
	logic [XW-1:0]              jmp_s1;

	// Result register.
	logic          out_valid_q;
	logic [BW-1:0] out_byte_q;
	logic [BW-1:0] out_count_q;
	logic [PW-1:0] next_q;
	logic          halted_q;
	logic          fault_q;

	// Tape RAM ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [BW-1:0] ram_wdata;
	logic          ram_re;
	logic [BW-1:0] tape_rd;

	logic accept;
	logic out_free;
	logic finish;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_EXEC) && out_free;

	// Upper reduction steps of the jump target, straight from the input fields.
	logic [XW-1:0] jmp_pre;
	always_comb begin
		jmp_pre = XW'(match_index) + XW'(1);
		for (int k = QB - 1; k >= SPLIT; k--) begin
			jmp_pre = tmte_pkg::mod_step(jmp_pre, tmte_pkg::MOD_W'(PROGRAM_DEPTH) << k);
		end
	end

	// Lower reduction steps; the result is below PROGRAM_DEPTH.
	logic [XW-1:0] jmp_red;
	logic [PW-1:0] jmp_tgt;
	always_comb begin
		jmp_red = jmp_s1;
		for (int k = SPLIT - 1; k >= 0; k--) begin
			jmp_red = tmte_pkg::mod_step(jmp_red, tmte_pkg::MOD_W'(PROGRAM_DEPTH) << k);
		end
		jmp_tgt = jmp_red[PW-1:0];
	end

	// Sequential program index with wrap.
	logic [PW-1:0] pidx_inc;
	assign pidx_inc = (pidx_q == PROG_MAX) ? '0 : pidx_q + PW'(1);

	// Pointer moves. With TAPE_DEPTH of at least 256 a right move stays below twice the depth, so one subtract wraps it;
	// a left move past zero wraps by adding the depth.
	logic [AW:0]   r_sum;
	logic [AW:0]   r_wrap;
	logic          r_out;
	logic [AW-1:0] r_np;
	logic [AW:0]   l_sum;
	logic          l_out;
	logic [AW-1:0] l_np;

	always_comb begin
		r_sum  = {1'b0, dp_q} + (AW + 1)'(amount_s1);
		r_out  = (r_sum >= TAPE_LIM);
		r_wrap = r_sum - TAPE_LIM;
		r_np   = r_out ? r_wrap[AW-1:0] : r_sum[AW-1:0];
		l_out  = ((AW + 1)'(amount_s1) > {1'b0, dp_q});
		l_sum  = {1'b0, dp_q} + (l_out ? TAPE_LIM : '0) - (AW + 1)'(amount_s1);
		l_np   = l_sum[AW-1:0];
	end

	// Token execution against the cell read in the accept cycle.
	logic [BW-1:0] ob_n;
	logic [BW-1:0] oc_n;
	logic          flt_n;
	logic [PW-1:0] nxt_n;
	logic          stop_n;
	logic [AW-1:0] dp_n;
	logic          wr_n;
	logic [BW-1:0] wval_n;

	always_comb begin
		ob_n   = '0;
		oc_n   = '0;
		flt_n  = 1'b0;
		nxt_n  = pidx_inc;
		stop_n = stopped_q;
		dp_n   = dp_q;
		wr_n   = 1'b0;
		wval_n = tape_rd;
		if (stopped_q) begin
			// A stopped machine ignores the word and repeats its index.
			nxt_n = pidx_q;
		end else begin
			case (action_s1)
				tmte_pkg::ACT_RIGHT: begin
					if (safe_mode_q && r_out) flt_n = 1'b1;
					else dp_n = r_np;
				end
				tmte_pkg::ACT_LEFT: begin
					if (safe_mode_q && l_out) flt_n = 1'b1;
					else dp_n = l_np;
				end
				tmte_pkg::ACT_ADD: begin
					wr_n   = 1'b1;
					wval_n = tape_rd + amount_s1;
				end
				tmte_pkg::ACT_SUB: begin
					wr_n   = 1'b1;
					wval_n = tape_rd - amount_s1;
				end
				tmte_pkg::ACT_OUT: begin
					ob_n = tape_rd;
					oc_n = amount_s1;
				end
				tmte_pkg::ACT_IN: begin
					// Only the last of the repeated reads survives; a zero count reads nothing.
					wr_n   = (amount_s1 != '0);
					wval_n = ibyte_s1;
				end
				tmte_pkg::ACT_JZ: begin
					if (tape_rd == '0) nxt_n = jmp_tgt;
				end
				tmte_pkg::ACT_JNZ: begin
					if (tape_rd != '0) nxt_n = jmp_tgt;
				end
				tmte_pkg::ACT_EXIT: begin
					stop_n = 1'b1;
					nxt_n  = pidx_q;
				end
				tmte_pkg::ACT_NOP: begin
				end
				default: begin
					// Undefined action codes fault in safe mode and are a no-op otherwise.
					if (safe_mode_q) flt_n = 1'b1;
				end
			endcase
			if (flt_n) begin
				stop_n = 1'b1;
				nxt_n  = pidx_q;
				ob_n   = '0;
				oc_n   = '0;
			end
		end
	end

	// RAM access: the clearing pass owns the write port after reset; otherwise the
	// write-back of the executing token. Reads are issued only on accept, so the read
	// data holds while a finished result waits for the output register.
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = finish && wr_n;
			ram_waddr = dp_q;
			ram_wdata = wval_n;
		end
		ram_re = accept;
	end

	tmte_ram #(
		.WIDTH (BW),
		.DEPTH (TAPE_DEPTH)
	) u_tape (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (dp_q),
		.rdata (tape_rd)
	);

	// Token fields are payload only and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			amount_s1 <= amount;
			ibyte_s1  <= input_byte;
			jmp_s1    <= jmp_pre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			dp_q        <= '0;
			pidx_q      <= '0;
			stopped_q   <= 1'b0;
			safe_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_count_q <= '0;
			next_q      <= '0;
			halted_q    <= 1'b0;
			fault_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				safe_mode_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == TAPE_MAX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						dp_q        <= dp_n;
						pidx_q      <= nxt_n;
						stopped_q   <= stop_n;
						out_valid_q <= 1'b1;
						out_byte_q  <= ob_n;
						out_count_q <= oc_n;
						next_q      <= nxt_n;
						halted_q    <= stop_n;
						fault_q     <= flt_n;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_count  = out_count_q;
	assign next_index = tmte_pkg::IDX_W'(next_q);
	assign halted     = halted_q;
	assign fault      = fault_q;

endmodule

/* rtl/core/tmte_checker.sv */
// Port-level checker for the tape machine token executor core, bound to its top level.
// Depends on tmte_pkg for field widths.
module tmte_props (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tmte_pkg::BYTE_W-1:0] out_byte,
	input logic [tmte_pkg::BYTE_W-1:0] out_count,
	input logic [tmte_pkg::IDX_W-1:0]  next_index,
	input logic                        halted,
	input logic                        fault
);

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_count)
			&& $stable(next_index) && $stable(halted) && $stable(fault))
		else $error("result word changed while stalled");

	// Each word occupies the tape until it finishes, so ready drops right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted in back-to-back cycles");

	// A fault always stops the machine.
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> halted)
		else $error("fault reported without halt");

	// A stopping or stopped word never prints anything.
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |-> out_count == '0 && out_byte == '0)
		else $error("halted result carries output");

endmodule

bind tape_machine_token_executor_core tmte_props u_tmte_props (.*);
